### src/mpma_pkg.sv
// Shared constants, codes, control structs and the pattern id helper of the pattern matching automaton.
`default_nettype none
package mpma_pkg;

    localparam int MAX_STATES   = 256;
    localparam int ALPHABET     = 6;
    localparam int MAX_PATTERNS = 16;

    localparam int STATE_W = $clog2(MAX_STATES);
    localparam int COUNT_W = STATE_W + 1;
    localparam int CH_W    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int ROW_W   = ALPHABET * STATE_W;
    localparam int PID_W   = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;

    typedef logic [1:0] cmd_code_t;
    localparam cmd_code_t CMD_PATTERN = 2'd0;
    localparam cmd_code_t CMD_BUILD   = 2'd1;
    localparam cmd_code_t CMD_TEXT    = 2'd2;
    localparam cmd_code_t CMD_CLEAR   = 2'd3;

    typedef logic [1:0] rd_sel_t;
    localparam rd_sel_t RD_INS  = 2'd0;
    localparam rd_sel_t RD_TXT  = 2'd1;
    localparam rd_sel_t RD_P    = 2'd2;
    localparam rd_sel_t RD_FAIL = 2'd3;

    typedef struct packed {
        logic    load_in;
        rd_sel_t rd_sel;
        logic    ins_step;
        logic    ins_zero;
        logic    txt_step;
        logic    clear_all;
        logic    rep_ins;
        logic    rep_txt;
        logic    rep_root;
        logic    walk_init;
        logic    walk_pop;
        logic    walk_load;
        logic    walk_latch;
        logic    walk_act;
    } dp_ctrl_t;

    typedef struct packed {
        cmd_code_t cmd;
        logic      sym_valid;
        logic      ins_new;
        logic      walk_more;
        logic      last_c;
    } dp_stat_t;

    function automatic logic [PID_W-1:0] sat_pid(input logic [3:0] pid);
        logic [PID_W-1:0] res;
        if (32'(pid) >= MAX_PATTERNS)
            res = PID_W'(MAX_PATTERNS - 1);
        else
            res = PID_W'(pid);
        return res;
    endfunction

endpackage
`default_nettype wire

### src/multi_pattern_match_automaton.sv
// Top level of the multi-pattern (Aho-Corasick) matching automaton.
//
// Requests enter on start/command/symbol/pattern_end/pattern_id and are taken
// at a clock edge where start is high and busy is low. Every request gives one
// result on state_index/terminal/matched_id/table_full, shown for exactly one
// cycle with done high; the receiver cannot stall it, so it must take it then.
// A clear or an invalid pattern or text symbol passes from dispatch straight
// to report and output; a text symbol adds a text step, and a pattern symbol
// an insert step, plus a row zeroing step when a new trie node is created;
// the next request is accepted the cycle after done. The goto row memory and
// the terminal memory are read through registers.
// A build request walks the trie breadth first: for each queued state a pop
// and a load, then six goto/failure read pairs through one memory port; once
// the queue is empty, report and output follow.
// Reset empties the trie at once: a root flag makes the root row read as zero
// until written, and rows of new nodes are zeroed as they are allocated, so
// no clearing pass is needed and the first request may follow reset directly.
`default_nettype none
module multi_pattern_match_automaton (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] command,
    input  wire logic [2:0] symbol,
    input  wire logic       pattern_end,
    input  wire logic [3:0] pattern_id,
    output logic            busy,
    output logic            done,
    output logic [7:0]      state_index,
    output logic            terminal,
    output logic [3:0]      matched_id,
    output logic            table_full
);
    import mpma_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    mpma_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (done)
    );

    mpma_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .command     (command),
        .symbol      (symbol),
        .pattern_end (pattern_end),
        .pattern_id  (pattern_id),
        .stat        (stat),
        .state_index (state_index),
        .terminal    (terminal),
        .matched_id  (matched_id),
        .table_full  (table_full)
    );

endmodule
`default_nettype wire

### src/mpma_ctrl.sv
// Controller state machine that sequences insert, text, build and clear requests.
`default_nettype none
module mpma_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire mpma_pkg::dp_stat_t stat,
    output mpma_pkg::dp_ctrl_t     ctrl,
    output logic                   busy,
    output logic                   done
);
    import mpma_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_INS   = 4'd2;
    localparam logic [3:0] S_INSZ  = 4'd3;
    localparam logic [3:0] S_TXT   = 4'd4;
    localparam logic [3:0] S_WPOP  = 4'd5;
    localparam logic [3:0] S_WLOAD = 4'd6;
    localparam logic [3:0] S_WRD   = 4'd7;
    localparam logic [3:0] S_WRDF  = 4'd8;
    localparam logic [3:0] S_WACT  = 4'd9;
    localparam logic [3:0] S_REP   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        ctrl       = '0;
        ctrl.rd_sel = RD_P;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load_in = 1'b1;
                    state_next   = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.cmd)
                    CMD_PATTERN:
                    begin
                        ctrl.rd_sel = RD_INS;
                        if (stat.sym_valid)
                            state_next = S_INS;
                        else
                        begin
                            ctrl.rep_ins = 1'b1;
                            state_next   = S_REP;
                        end
                    end
                    CMD_TEXT:
                    begin
                        ctrl.rd_sel = RD_TXT;
                        if (stat.sym_valid)
                            state_next = S_TXT;
                        else
                        begin
                            ctrl.rep_txt = 1'b1;
                            state_next   = S_REP;
                        end
                    end
                    CMD_BUILD:
                    begin
                        ctrl.walk_init = 1'b1;
                        state_next     = S_WPOP;
                    end
                    CMD_CLEAR:
                    begin
                        ctrl.clear_all = 1'b1;
                        state_next     = S_REP;
                    end
                    default: state_next = S_REP;
                endcase
            end
            S_INS:
            begin
                ctrl.ins_step = 1'b1;
                state_next    = stat.ins_new ? S_INSZ : S_REP;
            end
            S_INSZ:
            begin
                ctrl.ins_zero = 1'b1;
                state_next    = S_REP;
            end
            S_TXT:
            begin
                ctrl.txt_step = 1'b1;
                state_next    = S_REP;
            end
            S_WPOP:
            begin
                if (stat.walk_more)
                begin
                    ctrl.walk_pop = 1'b1;
                    state_next    = S_WLOAD;
                end
                else
                begin
                    ctrl.rep_root = 1'b1;
                    state_next    = S_REP;
                end
            end
            S_WLOAD:
            begin
                ctrl.walk_load = 1'b1;
                state_next     = S_WRD;
            end
            S_WRD:
            begin
                ctrl.rd_sel = RD_P;
                state_next  = S_WRDF;
            end
            S_WRDF:
            begin
                // The goto read now follows the failure link of the popped state.
                ctrl.rd_sel     = RD_FAIL;
                ctrl.walk_latch = 1'b1;
                state_next      = S_WACT;
            end
            S_WACT:
            begin
                ctrl.walk_act = 1'b1;
                state_next    = stat.last_c ? S_WPOP : S_WRD;
            end
            S_REP:   state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

endmodule
`default_nettype wire

### src/mpma_dp.sv
// Datapath: goto, failure, terminal and walk queue memories, cursors and counters.
`default_nettype none
module mpma_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mpma_pkg::dp_ctrl_t ctrl,
    input  wire mpma_pkg::cmd_code_t command,
    input  wire logic [2:0]         symbol,
    input  wire logic               pattern_end,
    input  wire logic [3:0]         pattern_id,
    output mpma_pkg::dp_stat_t      stat,
    output logic [7:0]              state_index,
    output logic                    terminal,
    output logic [3:0]              matched_id,
    output logic                    table_full
);
    import mpma_pkg::*;

    logic [ROW_W-1:0]   goto_mem [MAX_STATES];
    logic [STATE_W-1:0] fail_mem [MAX_STATES];
    logic [PID_W:0]     term_mem [MAX_STATES];
    logic [STATE_W-1:0] queue_mem [MAX_STATES];

    cmd_code_t          cmd_reg;
    logic [2:0]         sym_reg;
    logic               pend_reg;
    logic [3:0]         pid_reg;

    logic [STATE_W-1:0] ins_cur_reg, ins_cur_next;
    logic [STATE_W-1:0] txt_cur_reg, txt_cur_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               root_zero_reg, root_zero_next;
    logic [STATE_W-1:0] rep_state_reg, rep_state_next;
    logic               rep_full_reg, rep_full_next;
    logic [COUNT_W-1:0] head_reg, head_next;
    logic [COUNT_W-1:0] tail_reg, tail_next;
    logic [STATE_W-1:0] p_reg;
    logic [CH_W-1:0]    c_reg;
    logic [ROW_W-1:0]   row_p_reg;
    logic [STATE_W-1:0] new_node_reg;

    logic [ROW_W-1:0]   goto_q_reg;
    logic               goto_zero_reg;
    logic [STATE_W-1:0] fail_q_reg;
    logic [PID_W:0]     term_q_reg;
    logic [STATE_W-1:0] queue_q_reg;

    logic [STATE_W-1:0] goto_raddr;
    logic [ROW_W-1:0]   goto_row;
    logic               sym_valid;
    logic [CH_W-1:0]    ch;
    logic [STATE_W-1:0] q_cur;
    logic [STATE_W-1:0] q_walk;
    logic [STATE_W-1:0] f_walk;
    logic [STATE_W-1:0] q_new;
    logic               has_room;

    logic               goto_we;
    logic [STATE_W-1:0] goto_waddr;
    logic [ROW_W-1:0]   goto_wdata;
    logic               fail_we;
    logic [STATE_W-1:0] fail_waddr;
    logic [STATE_W-1:0] fail_wdata;
    logic               term_we;
    logic [STATE_W-1:0] term_waddr;
    logic [PID_W:0]     term_wdata;
    logic               queue_we;
    logic [STATE_W-1:0] queue_waddr;
    logic [STATE_W-1:0] queue_wdata;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            cmd_reg  <= command;
            sym_reg  <= symbol;
            pend_reg <= pattern_end;
            pid_reg  <= pattern_id;
        end
        if (ctrl.walk_load)
            p_reg <= queue_q_reg;
        if (ctrl.walk_load)
            c_reg <= '0;
        else if (ctrl.walk_act)
            c_reg <= c_reg + CH_W'(1);
        if (ctrl.walk_latch)
            row_p_reg <= goto_row;
        if (ctrl.ins_step)
            new_node_reg <= q_new;
    end

    // Memories: one write and one registered read each per cycle.
    always_ff @(posedge clk)
    begin
        if (goto_we)
            goto_mem[goto_waddr] <= goto_wdata;
        goto_q_reg <= goto_mem[goto_raddr];
        if (fail_we)
            fail_mem[fail_waddr] <= fail_wdata;
        fail_q_reg <= fail_mem[p_reg];
        if (term_we)
            term_mem[term_waddr] <= term_wdata;
        term_q_reg <= term_mem[rep_state_reg];
        if (queue_we)
            queue_mem[queue_waddr] <= queue_wdata;
        queue_q_reg <= queue_mem[head_reg[STATE_W-1:0]];
    end

    // The root row reads as all zero until it is written after reset or a clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            goto_zero_reg <= 1'b1;
        else
            goto_zero_reg <= root_zero_reg && (goto_raddr == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ins_cur_reg   <= '0;
            txt_cur_reg   <= '0;
            count_reg     <= COUNT_W'(1);
            root_zero_reg <= 1'b1;
            rep_state_reg <= '0;
            rep_full_reg  <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
        end
        else
        begin
            ins_cur_reg   <= ins_cur_next;
            txt_cur_reg   <= txt_cur_next;
            count_reg     <= count_next;
            root_zero_reg <= root_zero_next;
            rep_state_reg <= rep_state_next;
            rep_full_reg  <= rep_full_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_comb
    begin
        unique case (ctrl.rd_sel)
            RD_INS:  goto_raddr = ins_cur_reg;
            RD_TXT:  goto_raddr = txt_cur_reg;
            RD_P:    goto_raddr = p_reg;
            RD_FAIL: goto_raddr = fail_q_reg;
            default: goto_raddr = p_reg;
        endcase
    end

    assign goto_row  = goto_zero_reg ? '0 : goto_q_reg;
    assign sym_valid = (sym_reg >= 3'd1) && (32'(sym_reg) <= ALPHABET);
    assign ch        = CH_W'(sym_reg - 3'd1);
    assign q_cur     = goto_row[ch * STATE_W +: STATE_W];
    assign q_walk    = row_p_reg[c_reg * STATE_W +: STATE_W];
    assign f_walk    = (p_reg == '0) ? '0 : goto_row[c_reg * STATE_W +: STATE_W];
    assign has_room  = (count_reg < COUNT_W'(MAX_STATES));
    assign q_new     = (q_cur != '0) ? q_cur : count_reg[STATE_W-1:0];

    assign stat.cmd       = cmd_reg;
    assign stat.sym_valid = sym_valid;
    assign stat.ins_new   = (q_cur == '0) && has_room;
    assign stat.walk_more = (head_reg < tail_reg);
    assign stat.last_c    = (32'(c_reg) == ALPHABET - 1);

    always_comb
    begin
        ins_cur_next   = ins_cur_reg;
        txt_cur_next   = txt_cur_reg;
        count_next     = count_reg;
        root_zero_next = root_zero_reg;
        rep_state_next = rep_state_reg;
        rep_full_next  = rep_full_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;

        goto_we     = 1'b0;
        goto_waddr  = p_reg;
        goto_wdata  = row_p_reg;
        fail_we     = 1'b0;
        fail_waddr  = q_walk;
        fail_wdata  = f_walk;
        term_we     = 1'b0;
        term_waddr  = q_new;
        term_wdata  = {pend_reg, sat_pid(pid_reg)};
        queue_we    = 1'b0;
        queue_waddr = tail_reg[STATE_W-1:0];
        queue_wdata = q_walk;

        if (ctrl.ins_step)
        begin
            if (q_cur == '0 && !has_room)
            begin
                rep_state_next = ins_cur_reg;
                rep_full_next  = 1'b1;
                if (pend_reg)
                    ins_cur_next = '0;
            end
            else
            begin
                rep_state_next = q_new;
                rep_full_next  = 1'b0;
                ins_cur_next   = pend_reg ? '0 : q_new;
                term_we        = pend_reg || (q_cur == '0);
                if (q_cur == '0)
                begin
                    count_next = count_reg + COUNT_W'(1);
                    goto_we    = 1'b1;
                    goto_waddr = ins_cur_reg;
                    goto_wdata = goto_row;
                    goto_wdata[ch * STATE_W +: STATE_W] = q_new;
                    fail_we    = 1'b1;
                    fail_waddr = q_new;
                    fail_wdata = '0;
                end
            end
        end

        if (ctrl.ins_zero)
        begin
            goto_we    = 1'b1;
            goto_waddr = new_node_reg;
            goto_wdata = '0;
        end

        if (ctrl.txt_step)
        begin
            txt_cur_next   = q_cur;
            rep_state_next = q_cur;
            rep_full_next  = 1'b0;
        end

        if (ctrl.rep_ins)
        begin
            rep_state_next = ins_cur_reg;
            rep_full_next  = 1'b0;
        end

        if (ctrl.rep_txt)
        begin
            rep_state_next = txt_cur_reg;
            rep_full_next  = 1'b0;
        end

        if (ctrl.rep_root)
        begin
            rep_state_next = '0;
            rep_full_next  = 1'b0;
        end

        if (ctrl.clear_all)
        begin
            ins_cur_next   = '0;
            txt_cur_next   = '0;
            count_next     = COUNT_W'(1);
            root_zero_next = 1'b1;
            rep_state_next = '0;
            rep_full_next  = 1'b0;
        end

        if (ctrl.walk_init)
        begin
            head_next    = '0;
            tail_next    = COUNT_W'(1);
            txt_cur_next = '0;
            queue_we     = 1'b1;
            queue_waddr  = '0;
            queue_wdata  = '0;
        end

        if (ctrl.walk_pop)
            head_next = head_reg + COUNT_W'(1);

        if (ctrl.walk_act)
        begin
            if (q_walk != '0)
            begin
                fail_we = 1'b1;
                if (tail_reg < COUNT_W'(MAX_STATES))
                begin
                    queue_we  = 1'b1;
                    tail_next = tail_reg + COUNT_W'(1);
                end
            end
            else
            begin
                goto_we    = 1'b1;
                goto_waddr = p_reg;
                goto_wdata = row_p_reg;
                goto_wdata[c_reg * STATE_W +: STATE_W] = f_walk;
            end
        end

        if (goto_we && goto_waddr == '0)
            root_zero_next = 1'b0;
    end

    // The root is never marked; its terminal entry is not written after reset.
    assign state_index = 8'(rep_state_reg);
    assign terminal    = (rep_state_reg != '0) && term_q_reg[PID_W];
    assign matched_id  = terminal ? 4'(term_q_reg[PID_W-1:0]) : 4'd0;
    assign table_full  = rep_full_reg;

endmodule
`default_nettype wire

### src/mpma_checker.sv
// Port-level checker for the matching automaton and its bind to the top level.
`default_nettype none
module mpma_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [7:0] state_index,
    input wire logic       terminal,
    input wire logic [3:0] matched_id
);

    // A result is shown for one cycle only.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // An accepted request keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // A result only appears while a request is still open.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown while idle");

    // The root never ends a pattern.
    a_root_not_term: assert property (@(posedge clk) disable iff (!rst_n)
        (done && state_index == 8'd0) |-> (!terminal && matched_id == 4'd0))
        else $error("root reported as terminal");

endmodule

bind multi_pattern_match_automaton mpma_checker u_mpma_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .state_index (state_index),
    .terminal    (terminal),
    .matched_id  (matched_id)
);
`default_nettype wire
